>>> rtl/dcp_pkg.sv
`default_nettype none
package dcp_pkg;

  // number format
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // derived datapath widths
  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int ROOT_W   = DIFF_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int TARGET_W = COORD_WIDTH - 1;
  localparam int STIFF_W  = 17;
  localparam int EPS_W    = 16;
  localparam int ERR_W    = ROOT_W;
  localparam int GAIN_W   = ERR_W + STIFF_W - 16;
  localparam int Q_W      = FRAC_BITS + 1;
  localparam int MOVE_W   = GAIN_W + Q_W - FRAC_BITS;

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = STIFF_W;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON   = 1'b1;
  localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd65536;
  localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd66;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic [TARGET_W-1:0]           rest_length;
    logic                          first_pinned;
    logic                          second_pinned;
  } item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_dx;
    logic signed [COORD_WIDTH-1:0] first_dy;
    logic signed [COORD_WIDTH-1:0] second_dx;
    logic signed [COORD_WIDTH-1:0] second_dy;
    logic [COORD_WIDTH-1:0]        abs_error;
    logic                          satisfied;
  } result_t;

  // sideband carried through the square root pipeline
  typedef struct packed {
    logic [DIFF_W-1:0]   ax;
    logic [DIFF_W-1:0]   ay;
    logic                nx;
    logic                ny;
    logic [TARGET_W-1:0] target;
    logic                pin1;
    logic                pin2;
  } sq_side_t;

  // sideband carried through the divider pipeline
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [ERR_W-1:0]  aerr;
    logic              nerr;
    logic              nx;
    logic              ny;
    logic              pin1;
    logic              pin2;
    logic              sat;
  } div_side_t;

endpackage
`default_nettype wire

>>> rtl/distance_constraint_projection_core.sv
`default_nettype none
// Distance constraint projection for two 2D points in signed Q16.16. One
// constraint beat is taken every clock while item_stall is low; its result
// passes through the 33-stage square root pipeline (one root bit per stage) and the
// 17-stage direction divider (one quotient bit per stage), plus difference,
// square, sum, error, gain, scale and output stages. An output register with a
// skid entry keeps the input open while one finished result waits. The
// stiffness and epsilon registers are written through the cfg port, which
// is always ready; write them only while no beat is in flight.
module distance_constraint_projection_core import dcp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire item_t                 item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [ROOT_W-1:0] ONE_FIX = ROOT_W'(1) << FRAC_BITS;
  localparam logic [MOVE_W-1:0] MAX_POS = MOVE_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [MOVE_W-1:0] MAX_NEG = MOVE_W'(64'd1 << (COORD_WIDTH - 1));

  function automatic logic [COORD_WIDTH-1:0] sat_move(input logic neg,
                                                       input logic [MOVE_W-1:0] mag);
    logic [MOVE_W-1:0] v;
    if (!neg) begin
      v = (mag > MAX_POS) ? MAX_POS : mag;
      sat_move = COORD_WIDTH'(v);
    end else begin
      v = (mag > MAX_NEG) ? MAX_NEG : mag;
      sat_move = COORD_WIDTH'(MOVE_W'(0) - v);
    end
  endfunction

  // configuration registers
  logic [STIFF_W-1:0] stiffness;
  logic [EPS_W-1:0]   epsilon;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFF_RESET;
      epsilon   <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STIFFNESS: stiffness <= cfg_data[STIFF_W-1:0];
        REG_EPSILON:   epsilon   <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves unless the skid entry is occupied
  logic    en;
  logic    skid_full;
  result_t skid;

  assign en         = !skid_full;
  assign item_stall = skid_full;

  // stage 1: differences and magnitudes
  logic [DIFF_W-1:0] dx;
  logic [DIFF_W-1:0] dy;
  logic              s1_valid;
  sq_side_t          s1_side;

  always_comb begin
    dx = DIFF_W'(item.second_x) - DIFF_W'(item.first_x);
    dy = DIFF_W'(item.second_y) - DIFF_W'(item.first_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.nx     <= dx[DIFF_W-1];
      s1_side.ny     <= dy[DIFF_W-1];
      s1_side.ax     <= dx[DIFF_W-1] ? DIFF_W'(0) - dx : dx;
      s1_side.ay     <= dy[DIFF_W-1] ? DIFF_W'(0) - dy : dy;
      s1_side.target <= item.rest_length;
      s1_side.pin1   <= item.first_pinned;
      s1_side.pin2   <= item.second_pinned;
    end
  end

  // stage 2: squares
  logic            s2_valid;
  logic [SQ_W-1:0] s2_sqx;
  logic [SQ_W-1:0] s2_sqy;
  sq_side_t        s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx  <= SQ_W'(s1_side.ax) * SQ_W'(s1_side.ax);
      s2_sqy  <= SQ_W'(s1_side.ay) * SQ_W'(s1_side.ay);
      s2_side <= s1_side;
    end
  end

  // stage 3: sum of squares
  logic            s3_valid;
  logic [SQ_W-1:0] s3_sq;
  sq_side_t        s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sq   <= s2_sqx + s2_sqy;
      s3_side <= s2_side;
    end
  end

  // integer square root
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  dcp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .radicand  (s3_sq),
    .in_side   (s3_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // stage 4: coincidence check, error, divider operands
  logic              coinc;
  logic              sat;
  logic [ROOT_W-1:0] dist_e;
  logic [ROOT_W-1:0] tgt_w;
  logic              nerr;
  logic [ERR_W-1:0]  aerr;

  always_comb begin
    tgt_w  = ROOT_W'(sq_side.target);
    coinc  = (sq_root < ROOT_W'(epsilon)) || (sq_root == '0);
    sat    = coinc && (sq_side.target < TARGET_W'(epsilon));
    dist_e = coinc ? ONE_FIX : sq_root;
    nerr   = (dist_e < tgt_w);
    aerr   = nerr ? ERR_W'(tgt_w - dist_e) : ERR_W'(dist_e - tgt_w);
  end

  logic              s4_valid;
  logic [ROOT_W-1:0] s4_numx;
  logic [ROOT_W-1:0] s4_numy;
  logic [ROOT_W-1:0] s4_den;
  div_side_t         s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_numx      <= coinc ? ROOT_W'(1) : sq_side.ax;
      s4_numy      <= coinc ? ROOT_W'(0) : sq_side.ay;
      s4_den       <= coinc ? ROOT_W'(1) : sq_root;
      s4_side.gain <= '0;
      s4_side.aerr <= aerr;
      s4_side.nerr <= nerr;
      s4_side.nx   <= coinc ? 1'b0 : sq_side.nx;
      s4_side.ny   <= coinc ? 1'b0 : sq_side.ny;
      s4_side.pin1 <= sq_side.pin1;
      s4_side.pin2 <= sq_side.pin2;
      s4_side.sat  <= sat;
    end
  end

  // stage 5: gain = error times stiffness, halved when both points move
  logic [ERR_W+STIFF_W-1:0] gprod;
  logic [GAIN_W-1:0]        gain;
  div_side_t                s5_side_next;

  always_comb begin
    gprod = (ERR_W+STIFF_W)'(s4_side.aerr) * (ERR_W+STIFF_W)'(stiffness);
    if (s4_side.pin1 || s4_side.pin2) begin
      gain = GAIN_W'(gprod >> 16);
    end else begin
      gain = GAIN_W'(gprod >> 17);
    end
    s5_side_next      = s4_side;
    s5_side_next.gain = gain;
  end

  logic              s5_valid;
  logic [ROOT_W-1:0] s5_numx;
  logic [ROOT_W-1:0] s5_numy;
  logic [ROOT_W-1:0] s5_den;
  div_side_t         s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_numx <= s4_numx;
      s5_numy <= s4_numy;
      s5_den  <= s4_den;
      s5_side <= s5_side_next;
    end
  end

  // unit direction
  logic           dv_valid;
  logic [Q_W-1:0] ux;
  logic [Q_W-1:0] uy;
  div_side_t      dv_side;

  dcp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_valid),
    .num_x     (s5_numx),
    .num_y     (s5_numy),
    .den       (s5_den),
    .in_side   (s5_side),
    .out_valid (dv_valid),
    .ux        (ux),
    .uy        (uy),
    .out_side  (dv_side)
  );

  // stage 6: scale gain by direction
  logic              s6_valid;
  logic [MOVE_W-1:0] s6_mx;
  logic [MOVE_W-1:0] s6_my;
  div_side_t         s6_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_mx   <= MOVE_W'(((GAIN_W+Q_W)'(dv_side.gain) * (GAIN_W+Q_W)'(ux)) >> FRAC_BITS);
      s6_my   <= MOVE_W'(((GAIN_W+Q_W)'(dv_side.gain) * (GAIN_W+Q_W)'(uy)) >> FRAC_BITS);
      s6_side <= dv_side;
    end
  end

  // signs, saturation and pin masking
  result_t res;

  always_comb begin
    res = '0;
    res.abs_error = s6_side.aerr[ERR_W-1] ? {COORD_WIDTH{1'b1}}
                                          : s6_side.aerr[COORD_WIDTH-1:0];
    if (!s6_side.pin1) begin
      res.first_dx = sat_move(s6_side.nerr != s6_side.nx, s6_mx);
      res.first_dy = sat_move(s6_side.nerr != s6_side.ny, s6_my);
    end
    if (!s6_side.pin2) begin
      res.second_dx = sat_move(s6_side.nerr == s6_side.nx, s6_mx);
      res.second_dy = sat_move(s6_side.nerr == s6_side.ny, s6_my);
    end
    if (s6_side.sat) begin
      res = '0;
      res.satisfied = 1'b1;
    end
  end

  // output register with one skid entry
  logic push;
  logic take;

  assign push = en && s6_valid;
  assign take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (push) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (take) begin
      if (skid_full) begin
        skid_full <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!result_valid || take) begin
        result <= res;
      end else begin
        skid <= res;
      end
    end else if (take && skid_full) begin
      result <= skid;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dcp_sqrt.sv
`default_nettype none
module dcp_sqrt import dcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [SQ_W-1:0]   radicand,
  input  wire sq_side_t          in_side,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      root,
  output sq_side_t               out_side
);

  // stage registers, one root bit per stage
  logic              vld  [1:ROOT_W];
  logic [REM_W-1:0]  rem  [1:ROOT_W];
  logic [ROOT_W-1:0] rt   [1:ROOT_W];
  logic [SQ_W-1:0]   rad  [1:ROOT_W];
  sq_side_t          side [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              vld_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] rt_i;
    logic [SQ_W-1:0]   rad_i;
    sq_side_t          side_i;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  test;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rem_i  = '0;
      assign rt_i   = '0;
      assign rad_i  = radicand;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld[k];
      assign rem_i  = rem[k];
      assign rt_i   = rt[k];
      assign rad_i  = rad[k];
      assign side_i = side[k];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      trial = {rem_i, rad_i[SQ_W-1 -: 2]};
      test  = (REM_W+2)'({rt_i, 2'b01});
      ge    = (trial >= test);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? REM_W'(trial - test) : REM_W'(trial);
        rt[k+1]   <= {rt_i[ROOT_W-2:0], ge};
        rad[k+1]  <= {rad_i[SQ_W-3:0], 2'b00};
        side[k+1] <= side_i;
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule
`default_nettype wire

>>> rtl/dcp_div.sv
`default_nettype none
module dcp_div import dcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [ROOT_W-1:0] num_x,
  input  wire logic [ROOT_W-1:0] num_y,
  input  wire logic [ROOT_W-1:0] den,
  input  wire div_side_t         in_side,
  output logic                   out_valid,
  output logic [Q_W-1:0]         ux,
  output logic [Q_W-1:0]         uy,
  output div_side_t              out_side
);

  // stage registers, one quotient bit per stage for both lanes
  logic              vld  [1:Q_W];
  logic [ROOT_W-1:0] rx   [1:Q_W];
  logic [ROOT_W-1:0] ry   [1:Q_W];
  logic [Q_W-1:0]    qx   [1:Q_W];
  logic [Q_W-1:0]    qy   [1:Q_W];
  logic [ROOT_W-1:0] dd   [1:Q_W];
  div_side_t         side [1:Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    logic              vld_i;
    logic [ROOT_W-1:0] rx_i;
    logic [ROOT_W-1:0] ry_i;
    logic [Q_W-1:0]    qx_i;
    logic [Q_W-1:0]    qy_i;
    logic [ROOT_W-1:0] d_i;
    div_side_t         side_i;
    logic [ROOT_W:0]   tx;
    logic [ROOT_W:0]   ty;
    logic [ROOT_W:0]   dw;
    logic              gex;
    logic              gey;

    if (j == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rx_i   = num_x;
      assign ry_i   = num_y;
      assign qx_i   = '0;
      assign qy_i   = '0;
      assign d_i    = den;
      assign side_i = in_side;
      assign tx     = {1'b0, rx_i};
      assign ty     = {1'b0, ry_i};
    end else begin : g_next
      assign vld_i  = vld[j];
      assign rx_i   = rx[j];
      assign ry_i   = ry[j];
      assign qx_i   = qx[j];
      assign qy_i   = qy[j];
      assign d_i    = dd[j];
      assign side_i = side[j];
      assign tx     = {rx_i, 1'b0};
      assign ty     = {ry_i, 1'b0};
    end

    // restoring compare and subtract per lane
    always_comb begin
      dw  = {1'b0, d_i};
      gex = (tx >= dw);
      gey = (ty >= dw);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx[j+1]   <= gex ? ROOT_W'(tx - dw) : ROOT_W'(tx);
        ry[j+1]   <= gey ? ROOT_W'(ty - dw) : ROOT_W'(ty);
        qx[j+1]   <= {qx_i[Q_W-2:0], gex};
        qy[j+1]   <= {qy_i[Q_W-2:0], gey};
        dd[j+1]   <= d_i;
        side[j+1] <= side_i;
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign ux        = qx[Q_W];
  assign uy        = qy[Q_W];
  assign out_side  = side[Q_W];

endmodule
`default_nettype wire

>>> rtl/dcp_checker.sv
`default_nettype none
module dcp_checker import dcp_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_stall,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // input only stalls while a result is waiting
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with no result pending");

  // a satisfied constraint moves nothing and reports no error
  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.satisfied |->
      result.first_dx == '0 && result.first_dy == '0 &&
      result.second_dx == '0 && result.second_dy == '0 && result.abs_error == '0)
    else $error("satisfied result with nonzero payload");

  // reset empties the output side
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("output not empty after reset");

endmodule

bind distance_constraint_projection_core dcp_checker u_dcp_checker (.*);
`default_nettype wire
